// ===== design/mstb_pkg.sv =====
// Shared types, command codes and saturation helper for the timer slot bank.
package mstb_pkg;

  // Command codes carried in the command transaction
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_REWIND     = 2'd1,
    CMD_SCHEDULE   = 2'd2,
    CMD_DESCHEDULE = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  slot;
    logic [30:0] amount;
  } cmd_item_t;

  typedef struct packed {
    logic [4:0] expired_slot;
    logic       last;
  } report_item_t;

  // One memory word per slot
  typedef struct packed {
    logic [31:0]        period;
    logic signed [31:0] remaining;
  } slot_entry_t;

  // Result of one slot update
  typedef struct packed {
    logic signed [31:0] remaining;
    logic               expire;
  } alu_res_t;

  // Clamp a 33-bit signed value into the 32-bit signed range
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mstb_slot_alu.sv =====
// Per-slot count update for tick, rewind and schedule commands.
module mstb_slot_alu (
  input  mstb_pkg::cmd_t             op,
  input  mstb_pkg::slot_entry_t      entry,
  input  logic [30:0]                amount,
  output mstb_pkg::alu_res_t         res
);
  import mstb_pkg::*;

  logic signed [32:0] ext_rem;
  logic signed [32:0] ext_amt;
  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic signed [31:0] sum_sat;
  logic signed [31:0] diff_sat;
  logic               reach;

  // Widen operands and form both saturated results
  assign ext_rem  = {entry.remaining[31], entry.remaining};
  assign ext_amt  = {2'b00, amount};
  assign sum      = ext_rem + ext_amt;
  assign diff     = ext_rem - ext_amt;
  assign sum_sat  = sat33(sum);
  assign diff_sat = sat33(diff);

  // Rewind takes off one period once the count has reached it
  assign reach = $signed({sum_sat[31], sum_sat}) >= $signed({1'b0, entry.period});

  // Select the result for the command in flight
  always_comb begin
    res = '0;
    case (op)
      CMD_TICK: begin
        res.remaining = diff_sat;
        res.expire    = diff_sat[31] || (diff_sat == 32'sd0);
      end
      CMD_REWIND: begin
        res.remaining = reach ? (sum_sat - $signed(entry.period)) : sum_sat;
      end
      CMD_SCHEDULE: begin
        res.remaining = sum_sat;
      end
      default: begin
        res.remaining = entry.remaining;
      end
    endcase
  end

endmodule

// ===== design/multi_slot_timer_bank.sv =====
// Top level of the timer slot bank: command sequencer, slot memory and report output.
//
//   channel  | role    | handshake                    | payload
//   ---------+---------+------------------------------+---------------------------------
//   command  | receive | command_valid / command_stall | cmd_item_t {cmd, slot, amount}
//   report   | send    | report_valid / report_stall   | report_item_t {expired_slot, last}
//
// Deschedule and zero-amount tick or rewind complete in the accept cycle; schedule
// then writes its slot in ST_SCHED. Tick and rewind go through the accept cycle, a scan
// that reads every slot once and writes back each armed slot, pipelined over the single
// read and single write port, plus a flush state.
// Reset clears all armed flags and marks every memory entry unwritten (reads as zero).
// A stalled report pauses a tick scan only when a second expiry is found while the
// held report and the output register are both occupied; the flush cycle likewise
// holds until the final report can enter the output register.
module multi_slot_timer_bank #(
  parameter int SLOTS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    command_valid,
  output logic                    command_stall,
  input  mstb_pkg::cmd_item_t     command,
  output logic                    report_valid,
  input  logic                    report_stall,
  output mstb_pkg::report_item_t  report
);
  import mstb_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t           state;
  state_t           state_next;
  cmd_t             op;
  logic [30:0]      amt;
  logic [CW-1:0]    rd_cnt;
  logic             st_v;
  logic [SW-1:0]    st_idx;
  logic [SLOTS-1:0] armed;
  logic [SLOTS-1:0] written;
  logic             pend_v;
  logic [4:0]       pend_slot;

  slot_entry_t      mem [SLOTS];
  slot_entry_t      rdata;
  slot_entry_t      cur;
  slot_entry_t      wr_data;
  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic             wr_en;
  alu_res_t         alu_res;

  logic             accept;
  logic             slot_ok;
  logic             out_free;
  logic             st_armed;
  logic             st_expire;
  logic             adv;
  logic             issue;
  logic             scan_done;

  // Handshake and decode
  assign accept   = command_valid && !command_stall;
  assign slot_ok  = 32'(command.slot) < SLOTS;
  assign out_free = !report_valid || !report_stall;

  // Compute stage: entry of st_idx, unwritten entries read as zero
  assign cur       = written[st_idx] ? rdata : '0;
  assign st_armed  = armed[st_idx];
  assign st_expire = st_v && st_armed && (op == CMD_TICK) && alu_res.expire;
  assign adv       = !(st_expire && pend_v && !out_free);
  assign issue     = (state == ST_SCAN) && adv && (rd_cnt < CW'(SLOTS));
  assign scan_done = (state == ST_SCAN) && adv && (rd_cnt == CW'(SLOTS));

  mstb_slot_alu u_alu (
    .op     (op),
    .entry  (cur),
    .amount (amt),
    .res    (alu_res)
  );

  // Memory port control
  assign rd_en   = (accept && (command.cmd == CMD_SCHEDULE) && slot_ok) || issue;
  assign rd_addr = (state == ST_IDLE) ? SW'(command.slot) : rd_cnt[SW-1:0];
  assign wr_en   = (state == ST_SCHED) || ((state == ST_SCAN) && adv && st_v && st_armed);

  always_comb begin
    wr_data.remaining = alu_res.remaining;
    wr_data.period    = (state == ST_SCHED) ? {1'b0, amt} : cur.period;
  end

  // Slot memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[st_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and stall
  always_comb begin
    state_next    = state;
    command_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command.cmd)
            CMD_SCHEDULE: begin
              if (slot_ok) state_next = ST_SCHED;
            end
            CMD_TICK, CMD_REWIND: begin
              if (command.amount != '0) state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCHED: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_done) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: armed flags, written marks, pipeline and output valids
  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= '0;
      written      <= '0;
      st_v         <= 1'b0;
      pend_v       <= 1'b0;
      report_valid <= 1'b0;
      rd_cnt       <= '0;
    end else begin
      // Load the output register, or drop it once taken
      if (((state == ST_SCAN) && adv && st_expire && pend_v) ||
          ((state == ST_FLUSH) && pend_v && out_free)) begin
        report_valid <= 1'b1;
      end else if (report_valid && !report_stall) begin
        report_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          rd_cnt <= '0;
          if (accept && (command.cmd == CMD_DESCHEDULE) && slot_ok) begin
            armed[SW'(command.slot)] <= 1'b0;
          end
        end
        ST_SCHED: begin
          armed[st_idx]   <= 1'b1;
          written[st_idx] <= 1'b1;
        end
        ST_SCAN: begin
          if (adv) begin
            if (st_expire) begin
              armed[st_idx] <= 1'b0;
              pend_v        <= 1'b1;
            end
            st_v <= issue;
            if (issue) rd_cnt <= rd_cnt + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (pend_v && out_free) begin
            pend_v <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: latched command, stage index, held and output reports
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= command.cmd;
      amt    <= command.amount;
      st_idx <= SW'(command.slot);
    end else if (issue) begin
      st_idx <= rd_cnt[SW-1:0];
    end
    if ((state == ST_SCAN) && adv && st_expire) begin
      pend_slot <= 5'(st_idx);
      if (pend_v) begin
        report.expired_slot <= pend_slot;
        report.last         <= 1'b0;
      end
    end
    if ((state == ST_FLUSH) && pend_v && out_free) begin
      report.expired_slot <= pend_slot;
      report.last         <= 1'b1;
    end
  end

  // A held report exists only while a tick is being scanned or flushed
  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (state == ST_SCAN || state == ST_FLUSH))
    else $error("held report outside scan");

  // The compute stage is occupied only during a scan
  a_stage_in_scan: assert property (@(posedge clk) disable iff (rst)
    st_v |-> (state == ST_SCAN))
    else $error("compute stage valid outside scan");

  // A schedule write leaves its slot armed
  a_sched_arms: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCHED) |=> armed[$past(st_idx)])
    else $error("scheduled slot not armed");

endmodule
